// ===== design/lz_image_block_decoder_macros.svh =====
// Assertion macros shared by the LZ image block decoder RTL.
`ifndef LZ_IMAGE_BLOCK_DECODER_MACROS_SVH
`define LZ_IMAGE_BLOCK_DECODER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define LZD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked at every rising edge outside reset.
`define LZD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== design/lzd_pkg.sv =====
// Shared types and constants of the LZ image block decoder.
`default_nettype none
package lzd_pkg;

    // Parser phase between input bytes.
    typedef enum logic [1:0] {
        PHASE_CTRL = 2'd0,
        PHASE_LIT  = 2'd1,
        PHASE_REF2 = 2'd2
    } phase_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COPY_RD = 3'b010,
        ST_COPY_WR = 3'b100
    } seq_state_t;

    // One decoded pixel on its way to the output register.
    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       bad;
    } pix_t;

    localparam int          LIT_FLAG_BIT  = 7;
    localparam logic [7:0]  LIT_LEN_MASK  = 8'h7f;
    localparam logic [4:0]  COPY_LEN_MASK = 5'h1f;
    localparam logic [5:0]  MIN_COPY_LEN  = 6'd3;
    localparam int          DIST_W        = 11;
    localparam int          COUNT_W       = 11;
    localparam logic [10:0] MAX_DISTANCE  = 11'd1024;

endpackage
`default_nettype wire

// ===== design/lzd_history_ram.sv =====
// History window memory: one write port and one registered read port.
`default_nettype none
module lzd_history_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: the data appears in the cycle after rd_en.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/lzd_ctrl.sv =====
// Parser and copy sequencer: reads, checks and writes back the history window.
`default_nettype none
module lzd_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_new_image,
    output logic               emit_valid,
    input  wire logic          emit_ready,
    output lzd_pkg::pix_t      emit_pix,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_wr_addr,
    output logic [7:0]         mem_wr_data,
    output logic               mem_rd_en,
    output logic [AW-1:0]      mem_rd_addr,
    input  wire logic [7:0]    mem_rd_data
);

    localparam int SW = AW + 1;

    lzd_pkg::seq_state_t                 state_reg, state_next;
    lzd_pkg::phase_t                     phase_reg, phase_next;
    logic [7:0]                          lit_left_reg, lit_left_next;
    logic [5:0]                          copy_len_reg, copy_len_next;
    logic [1:0]                          off_high_reg, off_high_next;
    logic [AW-1:0]                       wp_reg, wp_next;
    logic [lzd_pkg::COUNT_W-1:0]         prod_reg, prod_next;
    logic [lzd_pkg::DIST_W-1:0]          dist_reg, dist_next;
    logic [5:0]                          remain_reg, remain_next;

    logic                                s_fire;
    lzd_pkg::phase_t                     phase_eff;
    logic [lzd_pkg::COUNT_W-1:0]         prod_eff;
    logic [lzd_pkg::COUNT_W-1:0]         prod_inc;
    logic [AW-1:0]                       wp_inc;
    logic [7:0]                          lit_dec;
    logic [SW-1:0]                       wp_ext, dist_ext, src_ext;
    logic                                copy_bad;

    // Input transfers are taken only between copies; a literal needs a free output slot.
    assign s_ready = (state_reg == lzd_pkg::ST_IDLE) &&
                     (emit_ready || (phase_reg != lzd_pkg::PHASE_LIT));
    assign s_fire  = s_valid && s_ready;

    // A new image restarts the parser and the produced count before the byte is used.
    assign phase_eff = s_new_image ? lzd_pkg::PHASE_CTRL : phase_reg;
    assign prod_eff  = s_new_image ? '0 : prod_reg;

    // Pointer update shared by every emitted pixel; count update and run decrement for literals.
    assign wp_inc   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign prod_inc = (prod_eff < lzd_pkg::MAX_DISTANCE) ? prod_eff + 1'b1 : prod_eff;
    assign lit_dec  = (lit_left_reg != 8'd0) ? lit_left_reg - 8'd1 : 8'd0;

    // Source address of the next copied byte, modulo the window depth.
    assign wp_ext   = {1'b0, wp_reg};
    assign dist_ext = SW'(dist_reg);
    assign src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                           : (wp_ext + SW'(DEPTH) - dist_ext);
    assign copy_bad = dist_reg > prod_reg;

    // Sequencer and parser next state.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        copy_len_next = copy_len_reg;
        off_high_next = off_high_reg;
        wp_next       = wp_reg;
        prod_next     = prod_reg;
        dist_next     = dist_reg;
        remain_next   = remain_reg;
        emit_valid    = 1'b0;
        emit_pix      = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = wp_reg;
        mem_wr_data   = 8'd0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = src_ext[AW-1:0];

        unique case (state_reg)
            lzd_pkg::ST_IDLE: begin
                if (s_fire) begin
                    prod_next = prod_eff;
                    unique case (phase_eff)
                        lzd_pkg::PHASE_LIT: begin
                            emit_valid     = 1'b1;
                            emit_pix.pixel = s_data_byte;
                            emit_pix.last  = 1'b1;
                            emit_pix.bad   = 1'b0;
                            mem_wr_en      = 1'b1;
                            mem_wr_data    = s_data_byte;
                            wp_next        = wp_inc;
                            prod_next      = prod_inc;
                            lit_left_next  = lit_dec;
                            if (lit_dec == 8'd0) begin
                                phase_next = lzd_pkg::PHASE_CTRL;
                            end
                        end
                        lzd_pkg::PHASE_REF2: begin
                            dist_next     = {1'b0, off_high_reg, s_data_byte} + 11'd1;
                            remain_next   = copy_len_reg;
                            phase_next    = lzd_pkg::PHASE_CTRL;
                            copy_len_next = 6'd0;
                            off_high_next = 2'd0;
                            if (copy_len_reg != 6'd0) begin
                                state_next = lzd_pkg::ST_COPY_RD;
                            end
                        end
                        default: begin
                            // Control byte: open a literal run or the first half of a reference.
                            if (s_data_byte[lzd_pkg::LIT_FLAG_BIT]) begin
                                lit_left_next = (s_data_byte & lzd_pkg::LIT_LEN_MASK) + 8'd1;
                                phase_next    = lzd_pkg::PHASE_LIT;
                                copy_len_next = 6'd0;
                                off_high_next = 2'd0;
                            end else begin
                                copy_len_next = {1'b0, s_data_byte[6:2] & lzd_pkg::COPY_LEN_MASK}
                                                + lzd_pkg::MIN_COPY_LEN;
                                off_high_next = s_data_byte[1:0];
                                phase_next    = lzd_pkg::PHASE_REF2;
                                lit_left_next = 8'd0;
                            end
                        end
                    endcase
                end
            end
            lzd_pkg::ST_COPY_RD: begin
                mem_rd_en  = 1'b1;
                state_next = lzd_pkg::ST_COPY_WR;
            end
            lzd_pkg::ST_COPY_WR: begin
                if (emit_ready) begin
                    emit_valid     = 1'b1;
                    emit_pix.pixel = copy_bad ? 8'd0 : mem_rd_data;
                    emit_pix.last  = (remain_reg == 6'd1);
                    emit_pix.bad   = copy_bad;
                    mem_wr_en      = 1'b1;
                    mem_wr_data    = copy_bad ? 8'd0 : mem_rd_data;
                    wp_next        = wp_inc;
                    prod_next      = (prod_reg < lzd_pkg::MAX_DISTANCE) ? prod_reg + 1'b1
                                                                        : prod_reg;
                    remain_next    = remain_reg - 6'd1;
                    state_next     = (remain_reg == 6'd1) ? lzd_pkg::ST_IDLE
                                                          : lzd_pkg::ST_COPY_RD;
                end
            end
            default: begin
                state_next = lzd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lzd_pkg::ST_IDLE;
            phase_reg    <= lzd_pkg::PHASE_CTRL;
            lit_left_reg <= 8'd0;
            copy_len_reg <= 6'd0;
            off_high_reg <= 2'd0;
            wp_reg       <= '0;
            prod_reg     <= '0;
            remain_reg   <= 6'd0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            copy_len_reg <= copy_len_next;
            off_high_reg <= off_high_next;
            wp_reg       <= wp_next;
            prod_reg     <= prod_next;
            remain_reg   <= remain_next;
        end
    end

    // Distance of the copy in progress.
    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
    end

`include "lz_image_block_decoder_macros.svh"

    `LZD_ASSERT_IMP(a_emit_into_free_slot, aclk, aresetn, emit_valid, emit_ready, "pixel pushed into a full output register")
    `LZD_ASSERT_IMP(a_read_before_write, aclk, aresetn, state_reg == lzd_pkg::ST_COPY_WR, $past(state_reg) == lzd_pkg::ST_COPY_RD || $past(state_reg) == lzd_pkg::ST_COPY_WR, "copy write without a preceding history read")
    `LZD_ASSERT_IMP(a_no_input_during_copy, aclk, aresetn, state_reg != lzd_pkg::ST_IDLE, !s_ready, "input taken while a copy is running")
    `LZD_ASSERT_ALWAYS(a_count_saturates, aclk, aresetn, prod_reg <= lzd_pkg::MAX_DISTANCE, "produced count beyond the largest distance")
    `LZD_ASSERT_NEXT(a_copy_ends_idle, aclk, aresetn, state_reg == lzd_pkg::ST_COPY_WR && emit_valid && emit_pix.last, state_reg == lzd_pkg::ST_IDLE, "sequencer did not return to idle after the last copied pixel")

endmodule
`default_nettype wire

// ===== design/lz_image_block_decoder.sv =====
// Top level of the LZ image block decoder with its output register.
//
//  Channel   Direction  Payload                                      Handshake
//  s_        in         s_data_byte[7:0], s_new_image                s_valid / s_ready
//  m_        out        m_pixel[7:0], m_last_of_run, m_bad_reference m_valid / m_ready
//
// A control byte or the first byte of a reference makes no pixel.
// A literal byte leaves its pixel in the output register.
// A reference second byte starts a copy of 3 to 34 pixels: each copied pixel is a
// history read in ST_COPY_RD followed by its write-back in ST_COPY_WR, which must land
// before the next read so that an overlapping copy sees it.
// Reset clears the parser, pointers and output valid; the window needs no clearing.
// A stalled output holds the copy sequencer in its write-back step and holds off literals.
`default_nettype none
module lz_image_block_decoder #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_new_image,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_pixel,
    output logic            m_last_of_run,
    output logic            m_bad_reference
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic           emit_valid;
    logic           emit_ready;
    lzd_pkg::pix_t  emit_pix;
    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    logic [7:0]     mem_wr_data;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;
    logic [7:0]     mem_rd_data;

    logic           m_valid_reg, m_valid_next;
    lzd_pkg::pix_t  m_pix_reg;

    // Parser and copy sequencer.
    lzd_ctrl #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_new_image (s_new_image),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit_pix    (emit_pix),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // History window.
    lzd_history_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The output slot is free when empty or when its pixel leaves in this transfer.
    assign emit_ready   = !m_valid_reg || m_ready;
    assign m_valid_next = emit_valid ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_pix_reg <= emit_pix;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel         = m_pix_reg.pixel;
    assign m_last_of_run   = m_pix_reg.last;
    assign m_bad_reference = m_pix_reg.bad;

endmodule
`default_nettype wire
